// ----- rtl/core/bdcl_pkg.sv -----
// shared types and constants for the double-click and latch qualifier
package bdcl_pkg;

    localparam int WORD_W   = 32;
    localparam int POS_W    = 5;
    localparam int CNT_W    = 4;
    localparam int REG_W    = 30;
    localparam int MASK_W   = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FLAG_BITS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALTERNATE_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LATCHED_MASK   = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] flags;
    } stage_t;

    typedef struct packed {
        logic [POS_W-1:0] watch_pos;
        logic [POS_W-1:0] alt_pos;
        logic             latched;
    } cell_cfg_t;

endpackage

// ----- rtl/core/bdcl_cell.sv -----
// one entry of the qualifier chain: hold counter plus registered flag word
module bdcl_cell #(
    parameter int HOLD_LIMIT    = 15,
    parameter int DOUBLE_WINDOW = 10,
    parameter int FLAG_WIDTH    = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  bdcl_pkg::cell_cfg_t cfg,
    input  bdcl_pkg::stage_t   stage_in,
    output bdcl_pkg::stage_t   stage_out
);
    import bdcl_pkg::*;

    localparam logic signed [CNT_W+1:0] LOWER = (CNT_W+2)'(HOLD_LIMIT - DOUBLE_WINDOW);
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(HOLD_LIMIT);

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    stage_t            stage_reg;
    stage_t            stage_next;
    logic              watch_ok;
    logic              alt_ok;
    logic              hit;
    logic              in_window;
    logic [WORD_W-1:0] flags_q;

    always_comb
    begin
        watch_ok  = ({{(WORD_W-POS_W){1'b0}}, cfg.watch_pos} < WORD_W'(FLAG_WIDTH));
        alt_ok    = ({{(WORD_W-POS_W){1'b0}}, cfg.alt_pos} < WORD_W'(FLAG_WIDTH));
        hit       = watch_ok && stage_in.flags[cfg.watch_pos];
        in_window = (cnt_reg < LIMIT) && ($signed({2'b00, cnt_reg}) > LOWER);
        flags_q   = stage_in.flags;
        cnt_next  = cnt_reg;
        if (hit)
        begin
            if (cfg.latched)
            begin
                if (cnt_reg == LIMIT)
                begin
                    flags_q[cfg.watch_pos] = 1'b0;
                end
            end
            else if (in_window && alt_ok)
            begin
                flags_q[cfg.alt_pos] = 1'b1;
            end
            cnt_next = LIMIT;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        stage_next.valid = stage_in.valid;
        stage_next.flags = flags_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            stage_reg <= '0;
        end
        else if (advance)
        begin
            stage_reg.valid <= stage_next.valid;
            stage_reg.flags <= stage_next.flags;
            if (stage_in.valid)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    assign stage_out = stage_reg;

endmodule

// ----- rtl/core/button_double_click_and_latch_qualifier.sv -----
// top level: config registers and the chain of qualifier cells
//
// channel  direction  handshake              payload
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in       in         in_valid / in_ready    raw_flags
// out      out        out_valid / out_ready  qualified_flags
//
// one item enters per cycle unless the output stalls; each item walks the cell chain,
// one cell a cycle while the chain advances, and is offered once it leaves the last cell.
// each cell holds its own hold counter and sees the previous item's update in time.
// reset clears the counters, the config registers and every stage valid bit.
// a stalled output freezes the whole chain; in_ready follows that stall.
module button_double_click_and_latch_qualifier #(
    parameter int NUM_ENTRIES   = 6,
    parameter int HOLD_LIMIT    = 15,
    parameter int DOUBLE_WINDOW = 10,
    parameter int FLAG_WIDTH    = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bdcl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bdcl_pkg::REG_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [bdcl_pkg::WORD_W-1:0]        raw_flags,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bdcl_pkg::WORD_W-1:0]        qualified_flags
);
    import bdcl_pkg::*;

    localparam logic [WORD_W-1:0] WORD_MASK =
        (FLAG_WIDTH >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << FLAG_WIDTH) - 64'd1);

    logic [REG_W-1:0]  flag_bits_reg;
    logic [REG_W-1:0]  alt_bits_reg;
    logic [MASK_W-1:0] latched_reg;
    logic              advance;
    stage_t            chain [NUM_ENTRIES+1];
    cell_cfg_t         cell_cfg [NUM_ENTRIES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_bits_reg <= '0;
            alt_bits_reg  <= '0;
            latched_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FLAG_BITS:      flag_bits_reg <= cfg_data;
                REG_ALTERNATE_BITS: alt_bits_reg  <= cfg_data;
                REG_LATCHED_MASK:   latched_reg   <= cfg_data[MASK_W-1:0];
                default:            ;
            endcase
        end
    end

    assign advance  = !chain[NUM_ENTRIES].valid || out_ready;
    assign in_ready = advance;

    assign chain[0].valid = in_valid;
    assign chain[0].flags = raw_flags & WORD_MASK;

    for (genvar i = 0; i < NUM_ENTRIES; i++)
    begin : g_cell
        if ((i + 1) * POS_W <= REG_W)
        begin : g_pos
            assign cell_cfg[i].watch_pos = flag_bits_reg[i*POS_W +: POS_W];
            assign cell_cfg[i].alt_pos   = alt_bits_reg[i*POS_W +: POS_W];
        end
        else
        begin : g_pos_none
            assign cell_cfg[i].watch_pos = '0;
            assign cell_cfg[i].alt_pos   = '0;
        end
        if (i < MASK_W)
        begin : g_type
            assign cell_cfg[i].latched = latched_reg[i];
        end
        else
        begin : g_type_none
            assign cell_cfg[i].latched = 1'b0;
        end

        bdcl_cell #(
            .HOLD_LIMIT    (HOLD_LIMIT),
            .DOUBLE_WINDOW (DOUBLE_WINDOW),
            .FLAG_WIDTH    (FLAG_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .cfg       (cell_cfg[i]),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    assign out_valid       = chain[NUM_ENTRIES].valid;
    assign qualified_flags = chain[NUM_ENTRIES].flags;

endmodule

// ----- verif/tb_button_double_click_and_latch_qualifier.sv -----
// self-checking testbench for the double-click and latch flag qualifier
module tb_button_double_click_and_latch_qualifier;
    import bdcl_pkg::*;

    localparam int NUM_CELLS     = 6;
    localparam int HOLD_LIMIT    = 15;
    localparam int DOUBLE_WINDOW = 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 100;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [WORD_W-1:0]    raw_flags = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [WORD_W-1:0]    qualified_flags;

    // predictor state
    logic [REG_W-1:0]     watch_pos_reg;
    logic [REG_W-1:0]     alt_pos_reg;
    logic [MASK_W-1:0]    latched_reg;
    logic [CNT_W-1:0]     hold_cnt [NUM_CELLS];

    logic [WORD_W-1:0]    poll_queue [$];
    logic [WORD_W-1:0]    expected_words [$];
    int                   items_pushed = 0;
    int                   items_taken = 0;
    int                   mismatch_count = 0;
    int                   cycle_count = 0;
    int                   gap_left = 0;
    int                   burst_left = 1;

    // press/release run generator per entry
    logic                 press_level [NUM_CELLS];
    int                   run_left [NUM_CELLS];

    button_double_click_and_latch_qualifier #(
        .NUM_ENTRIES   (NUM_CELLS),
        .HOLD_LIMIT    (HOLD_LIMIT),
        .DOUBLE_WINDOW (DOUBLE_WINDOW),
        .FLAG_WIDTH    (WORD_W)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .raw_flags       (raw_flags),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .qualified_flags (qualified_flags)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic [WORD_W-1:0] qualify_word(input logic [WORD_W-1:0] raw);
        logic [WORD_W-1:0] flags;
        logic [POS_W-1:0]  wpos;
        logic [POS_W-1:0]  apos;
        int                cnt;
        flags = raw;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            wpos = watch_pos_reg[POS_W*i +: POS_W];
            apos = alt_pos_reg[POS_W*i +: POS_W];
            cnt  = int'(hold_cnt[i]);
            if (flags[wpos])
            begin
                if (latched_reg[i])
                begin
                    if (cnt == HOLD_LIMIT)
                        flags[wpos] = 1'b0;
                end
                else if (cnt < HOLD_LIMIT && cnt > HOLD_LIMIT - DOUBLE_WINDOW)
                begin
                    flags[apos] = 1'b1;
                end
                hold_cnt[i] = CNT_W'(HOLD_LIMIT);
            end
            else if (cnt > 0)
            begin
                hold_cnt[i] = CNT_W'(cnt - 1);
            end
        end
        return flags;
    endfunction

    function automatic logic [WORD_W-1:0] next_poll_word();
        logic [WORD_W-1:0] w;
        logic [POS_W-1:0]  p;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        // sparse background so added flags show up
        w = $urandom & $urandom & $urandom;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            if (run_left[i] == 0)
            begin
                press_level[i] = !press_level[i];
                if (press_level[i])
                    run_left[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20)
                                                             : $urandom_range(1, 3);
                else
                    run_left[i] = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 20)
                                                             : $urandom_range(1, 10);
            end
            run_left[i] = run_left[i] - 1;
            p = watch_pos_reg[POS_W*i +: POS_W];
            w[p] = press_level[i];
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < 40)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic queue_poll(input logic [WORD_W-1:0] w);
        poll_queue.push_back(w);
        items_pushed++;
    endtask

    task automatic wait_drained();
        while (items_taken != items_pushed || expected_words.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        wait_drained();
        repeat (NUM_CELLS + 4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_FLAG_BITS:      watch_pos_reg = data;
            REG_ALTERNATE_BITS: alt_pos_reg   = data;
            REG_LATCHED_MASK:   latched_reg   = data[MASK_W-1:0];
            default:            ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // sender: bursts with random gaps
    always @(posedge clk)
    begin : sender
        logic keep;
        keep = in_valid;
        if (in_valid && in_ready)
        begin
            expected_words.push_back(qualify_word(raw_flags));
            items_taken++;
            keep = 1'b0;
        end
        if (!keep && rst_n)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (poll_queue.size() > 0)
            begin
                raw_flags <= poll_queue.pop_front();
                keep = 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        in_valid <= keep;
    end

    // receiver: rotates through four out_ready stall patterns
    always @(posedge clk)
    begin : receiver
        logic [WORD_W-1:0] want;
        logic              rdy;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch($sformatf("result %h with no item outstanding", qualified_flags));
            end
            else
            begin
                want = expected_words.pop_front();
                if (qualified_flags !== want)
                    report_mismatch($sformatf("qualified_flags %h, predicted %h",
                                              qualified_flags, want));
            end
        end
        case ((cycle_count >> 7) % 4)
            0:       rdy = 1'b1;
            1:       rdy = 1'($urandom_range(0, 1));
            2:       rdy = ($urandom_range(0, 3) == 0);
            default: rdy = (cycle_count % 8 != 5) && (cycle_count % 8 != 6);
        endcase
        out_ready <= rdy;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [REG_W-1:0]  fb;
        logic [REG_W-1:0]  ab;
        logic [MASK_W-1:0] lm;
        watch_pos_reg = '0;
        alt_pos_reg   = '0;
        latched_reg   = '0;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            hold_cnt[i]    = '0;
            press_level[i] = 1'b0;
            run_left[i]    = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: every entry double-click on flag 0
        queue_poll(32'h0000_0000);
        queue_poll(32'h0000_0001);
        queue_poll(32'h0000_0000);
        queue_poll(32'h0000_0001);

        // chained entries, two latched
        write_reg(REG_FLAG_BITS, {5'd3, 5'd30, 5'd31, 5'd2, 5'd1, 5'd0});
        write_reg(REG_ALTERNATE_BITS, {5'd31, 5'd29, 5'd0, 5'd0, 5'd2, 5'd1});
        write_reg(REG_LATCHED_MASK, REG_W'(6'b001100));
        queue_poll(32'hFFFF_FFFF);
        queue_poll(32'hFFFF_FFFF);
        queue_poll(32'h0000_0000);
        queue_poll(32'h0000_0001);
        queue_poll(32'h0000_0000);
        queue_poll(32'h0000_0001);
        queue_poll(32'h8000_0004);
        queue_poll(32'h8000_0004);
        queue_poll(32'h0000_0004);
        queue_poll(32'h0000_0008);
        queue_poll(32'h0000_0000);
        queue_poll(32'h0000_0008);
        queue_poll(32'h4000_0000);
        queue_poll(32'h0000_0000);
        queue_poll(32'h4000_0000);

        // extremes, and a write to the unused index
        write_reg(REG_FLAG_BITS, {REG_W{1'b1}});
        write_reg(REG_ALTERNATE_BITS, '0);
        write_reg(REG_LATCHED_MASK, REG_W'({MASK_W{1'b1}}));
        write_reg(REG_UNUSED, {REG_W{1'b1}});
        queue_poll(32'h8000_0000);
        queue_poll(32'h8000_0000);
        queue_poll(32'h7FFF_FFFF);
        write_reg(REG_LATCHED_MASK, '0);
        queue_poll(32'h8000_0000);
        queue_poll(32'h0000_0000);
        queue_poll(32'h8000_0000);

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            fb = REG_W'($urandom);
            ab = REG_W'($urandom);
            lm = MASK_W'($urandom);
            if (ph == 0)
            begin
                fb = '0;
                ab = '0;
                lm = '0;
            end
            else if (ph == 1)
            begin
                fb = {REG_W{1'b1}};
                ab = {REG_W{1'b1}};
                lm = {MASK_W{1'b1}};
            end
            else if (ph inside {2, 5})
            begin
                // each alternate flag feeds the next entry
                for (int i = 0; i < NUM_CELLS - 1; i++)
                    ab[POS_W*i +: POS_W] = fb[POS_W*(i+1) +: POS_W];
                lm = lm & 6'b100000;
            end
            write_reg(REG_FLAG_BITS, fb);
            write_reg(REG_ALTERNATE_BITS, ab);
            write_reg(REG_LATCHED_MASK, REG_W'(lm));
            if (ph == 4)
                write_reg(REG_UNUSED, REG_W'($urandom));
            repeat (PHASE_ITEMS)
                queue_poll(next_poll_word());
            wait_drained();
        end

        wait_drained();
        repeat (NUM_CELLS * 4) @(posedge clk);
        if (expected_words.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_words.size()));
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
